FILE: hdl/epd_pkg.sv
// ----------------------------------------------------------------------------
// epd_pkg: shared types and constants for the echo distance display
// Holds the pipeline depth, the reciprocal constants and the digit helper.
// ----------------------------------------------------------------------------
package epd_pkg;

    localparam int PIPE_DEPTH = 5;

    localparam int PULSE_W = 22;
    localparam int BUTTON_W = 2;
    localparam int DIGIT_W = 4;
    localparam int MM_W = 14;
    localparam int INCH_W = 10;
    localparam int PAIR_W = 7;

    // mm = floor(pulse * 17 / 5000) = (pulse * MM_RECIP) >> MM_SHIFT, exact over 22 bits
    localparam int MM_SHIFT = 32;
    localparam logic [23:0] MM_RECIP = 24'd14602889;

    // inches = floor(mm * 5 / 127) = (mm * INCH_RECIP) >> INCH_SHIFT, exact for mm < 16384
    localparam int INCH_SHIFT = 20;
    localparam logic [15:0] INCH_RECIP = 16'd41283;

    // quotients by 100 and by 12, shared shift, exact for values up to 16383
    localparam int QUO_SHIFT = 20;
    localparam logic [16:0] RECIP_100 = 17'd10486;
    localparam logic [16:0] RECIP_12 = 17'd87382;

    localparam logic [MM_W-1:0] MM_LIMIT = 14'd9999;
    localparam logic [PAIR_W-1:0] FEET_LIMIT = 7'd99;

    typedef enum logic [BUTTON_W-1:0] {
        BTN_NONE   = 2'd0,
        BTN_MM     = 2'd1,
        BTN_FTIN   = 2'd2,
        BTN_IGNORE = 2'd3
    } t_button;

    typedef struct packed {
        logic [PIPE_DEPTH-1:0] load;
        logic [PIPE_DEPTH-1:0] full;
    } t_pipe_ctrl;

    typedef struct packed {
        logic [DIGIT_W-1:0] tens;
        logic [DIGIT_W-1:0] ones;
    } t_digit_pair;

    // Split a value below 100 into two decimal digits.
    function automatic t_digit_pair split2(input logic [PAIR_W-1:0] x);
        t_digit_pair res;
        logic [DIGIT_W-1:0] tens;
        logic [PAIR_W-1:0] tens_x10;
        tens = '0;
        for (int k = 1; k < 10; k++) begin
            if (x >= PAIR_W'(k * 10)) begin
                tens = tens + 4'd1;
            end
        end
        tens_x10 = PAIR_W'({tens, 3'b000}) + PAIR_W'({tens, 1'b0});
        res.tens = tens;
        res.ones = DIGIT_W'(x - tens_x10);
        return res;
    endfunction

endpackage

FILE: hdl/epd_in_if.sv
// ----------------------------------------------------------------------------
// epd_in_if: input channel of the echo distance display
// Carries the button code and an optional echo pulse width.
// ----------------------------------------------------------------------------
interface epd_in_if;
    logic                          valid;
    logic                          ready;
    logic [epd_pkg::BUTTON_W-1:0]  button;
    logic                          sample_valid;
    logic [epd_pkg::PULSE_W-1:0]   echo_cycles;

    modport source (output valid, output button, output sample_valid, output echo_cycles,
                    input ready);
    modport sink (input valid, input button, input sample_valid, input echo_cycles,
                  output ready);
endinterface

FILE: hdl/epd_out_if.sv
// ----------------------------------------------------------------------------
// epd_out_if: result channel of the echo distance display
// Carries the ranger trigger, the update flag, four digits and the colon.
// ----------------------------------------------------------------------------
interface epd_out_if;
    logic                         valid;
    logic                         ready;
    logic                         trigger_reading;
    logic                         display_update;
    logic [epd_pkg::DIGIT_W-1:0]  digit_ones;
    logic [epd_pkg::DIGIT_W-1:0]  digit_tens;
    logic [epd_pkg::DIGIT_W-1:0]  digit_hundreds;
    logic [epd_pkg::DIGIT_W-1:0]  digit_thousands;
    logic                         colon_lit;

    modport source (output valid, output trigger_reading, output display_update,
                    output digit_ones, output digit_tens, output digit_hundreds,
                    output digit_thousands, output colon_lit, input ready);
    modport sink (input valid, input trigger_reading, input display_update,
                  input digit_ones, input digit_tens, input digit_hundreds,
                  input digit_thousands, input colon_lit, output ready);
endinterface

FILE: hdl/epd_pipe_ctrl.sv
// ----------------------------------------------------------------------------
// epd_pipe_ctrl: occupancy and load enables for the conversion pipeline
// Each stage loads when it is empty or when the stage after it moves on.
// ----------------------------------------------------------------------------
module epd_pipe_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_ready,
    output epd_pkg::t_pipe_ctrl o_ctrl
);

    logic [epd_pkg::PIPE_DEPTH-1:0] r_full;
    logic [epd_pkg::PIPE_DEPTH-1:0] n_full;
    logic [epd_pkg::PIPE_DEPTH-1:0] w_load;

    always_comb begin
        w_load[epd_pkg::PIPE_DEPTH-1] = !r_full[epd_pkg::PIPE_DEPTH-1] || i_out_ready;
        for (int k = epd_pkg::PIPE_DEPTH - 2; k >= 0; k--) begin
            w_load[k] = !r_full[k] || w_load[k+1];
        end
    end

    always_comb begin
        n_full = r_full;
        if (w_load[0]) begin
            n_full[0] = i_in_valid;
        end
        for (int k = 1; k < epd_pkg::PIPE_DEPTH; k++) begin
            if (w_load[k]) begin
                n_full[k] = r_full[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= '0;
        end else begin
            r_full <= n_full;
        end
    end

    assign o_ctrl.load = w_load;
    assign o_ctrl.full = r_full;

endmodule

FILE: hdl/echo_pulse_to_distance_digits.sv
// ----------------------------------------------------------------------------
// echo_pulse_to_distance_digits: echo pulse width to four display digits
// Five-stage pipeline from pulse width to millimetre or feet-inch digits.
// ----------------------------------------------------------------------------
// The block takes one transfer per clock cycle on i_req while the sink keeps up,
// and returns exactly one result per transfer on o_rsp, in order. An accepted
// item moves down the five-register chain below and leaves the output register
// on a transfer to the sink. The registers in that chain, in order, are the
// input register, one stage for each constant reciprocal multiplier (pulse to
// millimetres, millimetres to inches, the divide by 100 or 12), then remainder
// and digit split into the output register. Stalls back up stage by stage, so
// bubbles are squeezed out before i_req.ready drops. The button code updates the
// display mode at the moment of transfer, before that item's conversion. An
// item without a sample yields trigger_reading high and all-zero digits; an
// item with a sample yields display_update high, millimetres saturated at
// 9999 with the colon off, or feet (up to 99) and inches with the colon on.
// ----------------------------------------------------------------------------
module echo_pulse_to_distance_digits (
    input  logic       i_clk,
    input  logic       i_rst_n,
    epd_in_if.sink     i_req,
    epd_out_if.source  o_rsp
);

    localparam int D = epd_pkg::PIPE_DEPTH;

    epd_pkg::t_pipe_ctrl w_ctrl;
    logic                w_accept;

    epd_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_rsp.ready),
        .o_ctrl      (w_ctrl)
    );

    assign i_req.ready = w_ctrl.load[0];
    assign w_accept    = i_req.valid && w_ctrl.load[0];

    // ---- display mode: apply the button at transfer time ----
    logic r_inch_mode;
    logic n_inch_mode;

    always_comb begin
        n_inch_mode = r_inch_mode;
        case (epd_pkg::t_button'(i_req.button))
            epd_pkg::BTN_MM:     n_inch_mode = 1'b0;
            epd_pkg::BTN_FTIN:   n_inch_mode = 1'b1;
            epd_pkg::BTN_NONE:   n_inch_mode = r_inch_mode;
            epd_pkg::BTN_IGNORE: n_inch_mode = r_inch_mode;
            default:             n_inch_mode = r_inch_mode;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inch_mode <= 1'b0;
        end else if (w_accept) begin
            r_inch_mode <= n_inch_mode;
        end
    end

    // ---- stage 1: input register, item carries its own mode ----
    logic                        r1_smp;
    logic                        r1_mode;
    logic [epd_pkg::PULSE_W-1:0] r1_pulse;

    always_ff @(posedge i_clk) begin
        if (w_ctrl.load[0]) begin
            r1_smp   <= i_req.sample_valid;
            r1_mode  <= n_inch_mode;
            r1_pulse <= i_req.echo_cycles;
        end
    end

    // ---- stage 2: millimetres by reciprocal multiply ----
    localparam int MMP_W = epd_pkg::PULSE_W + 24;
    logic [MMP_W-1:0]         w_mm_prod;
    logic                     r2_smp;
    logic                     r2_mode;
    logic [epd_pkg::MM_W-1:0] r2_mm;

    assign w_mm_prod = MMP_W'(r1_pulse) * MMP_W'(epd_pkg::MM_RECIP);

    always_ff @(posedge i_clk) begin
        if (w_ctrl.load[1]) begin
            r2_smp  <= r1_smp;
            r2_mode <= r1_mode;
            r2_mm   <= w_mm_prod[epd_pkg::MM_SHIFT +: epd_pkg::MM_W];
        end
    end

    // ---- stage 3: saturated millimetres or total inches ----
    localparam int INP_W = epd_pkg::MM_W + 16;
    logic [INP_W-1:0]           w_in_prod;
    logic [epd_pkg::INCH_W-1:0] w_inches;
    logic [epd_pkg::MM_W-1:0]   w_mm_sat;
    logic                       r3_smp;
    logic                       r3_mode;
    logic [epd_pkg::MM_W-1:0]   r3_val;

    assign w_in_prod = INP_W'(r2_mm) * INP_W'(epd_pkg::INCH_RECIP);
    assign w_inches  = w_in_prod[epd_pkg::INCH_SHIFT +: epd_pkg::INCH_W];
    assign w_mm_sat  = (r2_mm > epd_pkg::MM_LIMIT) ? epd_pkg::MM_LIMIT : r2_mm;

    always_ff @(posedge i_clk) begin
        if (w_ctrl.load[2]) begin
            r3_smp  <= r2_smp;
            r3_mode <= r2_mode;
            r3_val  <= r2_mode ? epd_pkg::MM_W'(w_inches) : w_mm_sat;
        end
    end

    // ---- stage 4: hundreds of mm, or feet (divide by 12) ----
    localparam int QP_W = epd_pkg::MM_W + 17;
    logic [16:0]                w_recip;
    logic [QP_W-1:0]            w_q_prod;
    logic                       r4_smp;
    logic                       r4_mode;
    logic [epd_pkg::MM_W-1:0]   r4_val;
    logic [epd_pkg::PAIR_W-1:0] r4_q;

    assign w_recip  = r3_mode ? epd_pkg::RECIP_12 : epd_pkg::RECIP_100;
    assign w_q_prod = QP_W'(r3_val) * QP_W'(w_recip);

    always_ff @(posedge i_clk) begin
        if (w_ctrl.load[3]) begin
            r4_smp  <= r3_smp;
            r4_mode <= r3_mode;
            r4_val  <= r3_val;
            r4_q    <= w_q_prod[epd_pkg::QUO_SHIFT +: epd_pkg::PAIR_W];
        end
    end

    // ---- stage 5: remainder, feet limit, digit split, output register ----
    logic [epd_pkg::MM_W-1:0]   w_q_x100;
    logic [epd_pkg::MM_W-1:0]   w_q_x12;
    logic [epd_pkg::MM_W-1:0]   w_rem_full;
    logic [epd_pkg::PAIR_W-1:0] w_hi;
    logic [epd_pkg::PAIR_W-1:0] w_lo;
    epd_pkg::t_digit_pair       w_hi_dig;
    epd_pkg::t_digit_pair       w_lo_dig;

    assign w_q_x100   = epd_pkg::MM_W'({r4_q, 6'b0}) + epd_pkg::MM_W'({r4_q, 5'b0})
                      + epd_pkg::MM_W'({r4_q, 2'b0});
    assign w_q_x12    = epd_pkg::MM_W'({r4_q, 3'b0}) + epd_pkg::MM_W'({r4_q, 2'b0});
    assign w_rem_full = r4_val - (r4_mode ? w_q_x12 : w_q_x100);
    assign w_lo       = w_rem_full[epd_pkg::PAIR_W-1:0];
    // clamp feet; the inch part stays the true remainder
    assign w_hi       = (r4_mode && (r4_q > epd_pkg::FEET_LIMIT)) ? epd_pkg::FEET_LIMIT : r4_q;
    assign w_hi_dig   = epd_pkg::split2(w_hi);
    assign w_lo_dig   = epd_pkg::split2(w_lo);

    logic                        r5_trig;
    logic                        r5_upd;
    logic                        r5_colon;
    logic [epd_pkg::DIGIT_W-1:0] r5_d0;
    logic [epd_pkg::DIGIT_W-1:0] r5_d1;
    logic [epd_pkg::DIGIT_W-1:0] r5_d2;
    logic [epd_pkg::DIGIT_W-1:0] r5_d3;

    always_ff @(posedge i_clk) begin
        if (w_ctrl.load[4]) begin
            if (r4_smp) begin
                r5_trig  <= 1'b0;
                r5_upd   <= 1'b1;
                r5_colon <= r4_mode;
                r5_d0    <= w_lo_dig.ones;
                r5_d1    <= w_lo_dig.tens;
                r5_d2    <= w_hi_dig.ones;
                r5_d3    <= w_hi_dig.tens;
            end else begin
                // no sample: ask the ranger for a new reading, blank fields
                r5_trig  <= 1'b1;
                r5_upd   <= 1'b0;
                r5_colon <= 1'b0;
                r5_d0    <= '0;
                r5_d1    <= '0;
                r5_d2    <= '0;
                r5_d3    <= '0;
            end
        end
    end

    assign o_rsp.valid           = w_ctrl.full[D-1];
    assign o_rsp.trigger_reading = r5_trig;
    assign o_rsp.display_update  = r5_upd;
    assign o_rsp.colon_lit       = r5_colon;
    assign o_rsp.digit_ones      = r5_d0;
    assign o_rsp.digit_tens      = r5_d1;
    assign o_rsp.digit_hundreds  = r5_d2;
    assign o_rsp.digit_thousands = r5_d3;

    // ---- assertions ----
    // hold the mode unless a transfer is taken
    a_mode_on_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_inch_mode))
        else $error("display mode changed without an input transfer");

    // a result either triggers a reading or updates the display, never both
    a_trig_xor_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.trigger_reading ^ o_rsp.display_update))
        else $error("trigger and display update not exclusive");

    // every shown digit is decimal
    a_digits_bcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.digit_ones <= 4'd9) && (o_rsp.digit_tens <= 4'd9)
                     && (o_rsp.digit_hundreds <= 4'd9) && (o_rsp.digit_thousands <= 4'd9))
        else $error("digit out of decimal range");

    // feet-inch display: inch tens at most 1, and only on an update
    a_inch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.colon_lit) |-> (o_rsp.display_update
                                             && (o_rsp.digit_tens <= 4'd1)))
        else $error("inch field out of range");

endmodule

FILE: tb/sv/echo_pulse_to_distance_digits_tb.sv
// ----------------------------------------------------------------------------
// echo_pulse_to_distance_digits_tb: self-checking bench for the echo display
// Walks a directed table of corner cases, then random readings with button
// presses, under random stalls on both channels and one long output stall.
// Every result is matched in order against a built-in distance predictor or a hand-written result.
// ----------------------------------------------------------------------------
module echo_pulse_to_distance_digits_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOTAL_ITEMS    = 1700;
    localparam int QUIET_ITEMS    = 250;     // final stretch with no idling
    localparam int HOLD_AFTER     = 300;     // transfers before the long output stall
    localparam int HOLD_CYCLES    = 80;
    localparam int DRAIN_CYCLES   = 4 * epd_pkg::PIPE_DEPTH;
    localparam int CYCLE_LIMIT    = 400000;

    localparam logic [epd_pkg::PULSE_W-1:0] PULSE_MAX    = 22'h3FFFFF;
    // last pulse below 10000 mm
    localparam logic [epd_pkg::PULSE_W-1:0] PULSE_MM_TOP = 22'd2941176;

    // One request transfer.
    typedef struct packed {
        epd_pkg::t_button                button;
        logic                            sample_valid;
        logic [epd_pkg::PULSE_W-1:0]     echo_cycles;
    } t_echo_item;

    // One display result, leftmost digit first.
    typedef struct packed {
        logic                            trigger_reading;
        logic                            display_update;
        logic [epd_pkg::DIGIT_W-1:0]     digit_thousands;
        logic [epd_pkg::DIGIT_W-1:0]     digit_hundreds;
        logic [epd_pkg::DIGIT_W-1:0]     digit_tens;
        logic [epd_pkg::DIGIT_W-1:0]     digit_ones;
        logic                            colon_lit;
    } t_display;

    // Directed table row: stimulus plus an optional hand-written result.
    typedef struct packed {
        t_echo_item  item;
        logic        typed;
        t_display    want;
    } t_probe_row;

    logic i_clk;
    logic i_rst_n;

    epd_in_if  echo_req ();
    epd_out_if echo_rsp ();

    echo_pulse_to_distance_digits uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (echo_req),
        .o_rsp   (echo_rsp)
    );

    // Predictor state and the in-order store of expected displays.
    logic         inch_mode_q;
    t_display     pending_displays[$];
    int unsigned  error_count;
    int unsigned  transfer_count;
    int unsigned  cycle_count;
    logic         quiet_phase;
    logic         hold_done;

    // Clock: 4 ns period.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hold reset low from the start, then release it for good.
    initial begin
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Predict the display for one transfer. The button acts first, then the
    // pulse is converted in the mode it leaves behind.
    function automatic t_display predict_display(input t_echo_item it);
        t_display     res;
        longint unsigned mm;
        int unsigned  total_in;
        int unsigned  feet;
        int unsigned  inches;
        res = '0;
        if (it.button == epd_pkg::BTN_MM) begin
            inch_mode_q = 1'b0;
        end else if (it.button == epd_pkg::BTN_FTIN) begin
            inch_mode_q = 1'b1;
        end
        if (!it.sample_valid) begin
            // no reading: ask for one, leave the digits blank
            res.trigger_reading = 1'b1;
        end else begin
            res.display_update = 1'b1;
            mm = (longint'(it.echo_cycles) * 17) / 5000;
            if (!inch_mode_q) begin
                if (mm > 9999) begin
                    mm = 9999;
                end
                res.digit_ones      = epd_pkg::DIGIT_W'(mm % 10);
                res.digit_tens      = epd_pkg::DIGIT_W'((mm / 10) % 10);
                res.digit_hundreds  = epd_pkg::DIGIT_W'((mm / 100) % 10);
                res.digit_thousands = epd_pkg::DIGIT_W'((mm / 1000) % 10);
            end else begin
                // convert on the unclamped millimetres
                total_in = int'((mm * 5) / 127);
                feet     = total_in / 12;
                inches   = total_in % 12;
                if (feet > 99) begin
                    feet = 99;
                end
                res.digit_ones      = epd_pkg::DIGIT_W'(inches % 10);
                res.digit_tens      = epd_pkg::DIGIT_W'(inches / 10);
                res.digit_hundreds  = epd_pkg::DIGIT_W'(feet % 10);
                res.digit_thousands = epd_pkg::DIGIT_W'(feet / 10);
                res.colon_lit       = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic t_probe_row row(input epd_pkg::t_button btn, input logic sv,
                                       input logic [epd_pkg::PULSE_W-1:0] pw,
                                       input logic typed, input t_display want);
        t_probe_row r;
        r.item.button       = btn;
        r.item.sample_valid = sv;
        r.item.echo_cycles  = pw;
        r.typed             = typed;
        r.want              = want;
        return r;
    endfunction

    function automatic t_echo_item random_reading();
        t_echo_item it;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)      it.button = epd_pkg::BTN_NONE;
        else if (pick < 72) it.button = epd_pkg::BTN_MM;
        else if (pick < 89) it.button = epd_pkg::BTN_FTIN;
        else                it.button = epd_pkg::BTN_IGNORE;
        it.sample_valid = ($urandom_range(0, 4) != 0);
        case ($urandom_range(0, 4))
            0: it.echo_cycles = epd_pkg::PULSE_W'($urandom_range(0, PULSE_MAX));
            1: it.echo_cycles = epd_pkg::PULSE_W'($urandom_range(0, PULSE_MM_TOP));
            2: it.echo_cycles = epd_pkg::PULSE_W'($urandom_range(0, 20000));
            3: it.echo_cycles = epd_pkg::PULSE_W'($urandom_range(PULSE_MM_TOP - 200,
                                                                 PULSE_MM_TOP + 200));
            default: it.echo_cycles = epd_pkg::PULSE_W'($urandom);
        endcase
        return it;
    endfunction

    // Offer one item and hold it until the transfer happens.
    task automatic offer_item(input t_echo_item it);
        echo_req.valid        <= 1'b1;
        echo_req.button       <= it.button;
        echo_req.sample_valid <= it.sample_valid;
        echo_req.echo_cycles  <= it.echo_cycles;
        do @(posedge i_clk); while (!echo_req.ready);
    endtask

    // Report one field that differs from its expectation.
    task automatic check_field(input string name, input logic [epd_pkg::DIGIT_W-1:0] want,
                               input logic [epd_pkg::DIGIT_W-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
            error_count++;
        end
    endtask

    // Stimulus: directed table, then random readings, then drain and judge.
    initial begin
        t_probe_row  probes[$];
        t_echo_item  it;
        t_display    want;
        echo_req.valid        = 1'b0;
        echo_req.button       = epd_pkg::BTN_NONE;
        echo_req.sample_valid = 1'b0;
        echo_req.echo_cycles  = '0;
        inch_mode_q    = 1'b0;
        error_count    = 0;
        transfer_count = 0;
        quiet_phase    = 1'b0;

        // first row: no sample right after reset asks for a reading
        probes.push_back(row(epd_pkg::BTN_NONE, 1'b0, '0, 1'b1,
                             {1'b1, 1'b0, 4'd0, 4'd0, 4'd0, 4'd0, 1'b0}));
        probes.push_back(row(epd_pkg::BTN_NONE, 1'b1, '0, 1'b1,
                             {1'b0, 1'b1, 4'd0, 4'd0, 4'd0, 4'd0, 1'b0}));
        // longest pulse clamps to 9999 mm
        probes.push_back(row(epd_pkg::BTN_NONE, 1'b1, PULSE_MAX, 1'b1,
                             {1'b0, 1'b1, 4'd9, 4'd9, 4'd9, 4'd9, 1'b0}));
        // same pulse in feet and inches: 561 in = 46 ft 9 in
        probes.push_back(row(epd_pkg::BTN_FTIN, 1'b1, PULSE_MAX, 1'b1,
                             {1'b0, 1'b1, 4'd4, 4'd6, 4'd0, 4'd9, 1'b1}));
        // no sample in inch mode still blanks the colon
        probes.push_back(row(epd_pkg::BTN_NONE, 1'b0, PULSE_MAX, 1'b1,
                             {1'b1, 1'b0, 4'd0, 4'd0, 4'd0, 4'd0, 1'b0}));
        // ignored button keeps inch mode
        probes.push_back(row(epd_pkg::BTN_IGNORE, 1'b1, '0, 1'b1,
                             {1'b0, 1'b1, 4'd0, 4'd0, 4'd0, 4'd0, 1'b1}));
        // mode switch on an item without a sample must stick
        probes.push_back(row(epd_pkg::BTN_MM, 1'b0, '0, 1'b1,
                             {1'b1, 1'b0, 4'd0, 4'd0, 4'd0, 4'd0, 1'b0}));
        probes.push_back(row(epd_pkg::BTN_NONE, 1'b1, PULSE_MM_TOP, 1'b0, '0));
        probes.push_back(row(epd_pkg::BTN_NONE, 1'b1, PULSE_MM_TOP + 1, 1'b0, '0));
        probes.push_back(row(epd_pkg::BTN_NONE, 1'b1, 22'd294, 1'b0, '0));
        probes.push_back(row(epd_pkg::BTN_NONE, 1'b1, 22'd295, 1'b0, '0));
        probes.push_back(row(epd_pkg::BTN_FTIN, 1'b0, '0, 1'b0, '0));
        probes.push_back(row(epd_pkg::BTN_NONE, 1'b1, 22'd89706, 1'b0, '0));
        probes.push_back(row(epd_pkg::BTN_NONE, 1'b1, 22'd89705, 1'b0, '0));
        probes.push_back(row(epd_pkg::BTN_IGNORE, 1'b1, 22'h2AAAAA, 1'b0, '0));
        probes.push_back(row(epd_pkg::BTN_MM, 1'b1, 22'h155555, 1'b0, '0));
        probes.push_back(row(epd_pkg::BTN_FTIN, 1'b1, 22'h155555, 1'b0, '0));
        probes.push_back(row(epd_pkg::BTN_MM, 1'b1, 22'h2AAAAA, 1'b0, '0));
        probes.push_back(row(epd_pkg::BTN_IGNORE, 1'b0, PULSE_MAX, 1'b0, '0));

        wait (i_rst_n);
        @(posedge i_clk);

        // Walk the directed table back to back.
        foreach (probes[k]) begin
            offer_item(probes[k].item);
            want = predict_display(probes[k].item);
            if (probes[k].typed) begin
                want = probes[k].want;
            end
            pending_displays.push_back(want);
            transfer_count++;
        end

        // Random readings with sender gaps until the quiet stretch.
        while (transfer_count < TOTAL_ITEMS) begin
            if (TOTAL_ITEMS - transfer_count <= QUIET_ITEMS) begin
                quiet_phase = 1'b1;
            end
            if (!quiet_phase && $urandom_range(0, 4) == 0) begin
                echo_req.valid <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end
            it = random_reading();
            offer_item(it);
            pending_displays.push_back(predict_display(it));
            transfer_count++;
        end
        echo_req.valid <= 1'b0;

        // Drain: wait for every display, then a few more cycles for strays.
        while (pending_displays.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Result sink: random stall bursts, one long hold-off to fill the
    // pipeline and force backpressure on the request side, none at the end.
    initial begin
        echo_rsp.ready = 1'b0;
        hold_done      = 1'b0;
        wait (i_rst_n);
        forever begin
            if (!hold_done && transfer_count >= HOLD_AFTER) begin
                echo_rsp.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
                echo_rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end else begin
                echo_rsp.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    // Match each result transfer against the oldest pending display.
    always @(posedge i_clk) begin
        t_display got;
        t_display want;
        if (i_rst_n && echo_rsp.valid && echo_rsp.ready) begin
            got = {echo_rsp.trigger_reading, echo_rsp.display_update,
                   echo_rsp.digit_thousands, echo_rsp.digit_hundreds,
                   echo_rsp.digit_tens, echo_rsp.digit_ones, echo_rsp.colon_lit};
            if (pending_displays.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual %h", $time, got);
                error_count++;
            end else begin
                want = pending_displays.pop_front();
                check_field("trigger_reading", epd_pkg::DIGIT_W'(want.trigger_reading),
                            epd_pkg::DIGIT_W'(got.trigger_reading));
                check_field("display_update", epd_pkg::DIGIT_W'(want.display_update),
                            epd_pkg::DIGIT_W'(got.display_update));
                check_field("digit_thousands", want.digit_thousands, got.digit_thousands);
                check_field("digit_hundreds", want.digit_hundreds, got.digit_hundreds);
                check_field("digit_tens", want.digit_tens, got.digit_tens);
                check_field("digit_ones", want.digit_ones, got.digit_ones);
                check_field("colon_lit", epd_pkg::DIGIT_W'(want.colon_lit),
                            epd_pkg::DIGIT_W'(got.colon_lit));
            end
        end
    end

    // Watchdog: end a hung run.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("%0t ns: timeout with %0d results pending",
                         $time, pending_displays.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

endmodule
